>>> design/imd_pkg.sv
// ----------------------------------------------------------------------------
// imd_pkg - shared types and constants of the interval multiplier
// Sign classes of an interval, pipeline sideband and binary64 constants.
// ----------------------------------------------------------------------------
package imd_pkg;

  // sign class of one interval operand
  typedef enum logic [1:0] {
    CLS_NONNEG   = 2'd0,
    CLS_NONPOS   = 2'd1,
    CLS_STRADDLE = 2'd2
  } sign_class_e;

  // flags that follow a beat down the multiplier pipeline
  typedef struct packed {
    logic both_straddle;  // both operands straddle zero: bounds are maxima
    logic zf_low;         // lower bound product has a zero factor
    logic zf_high;        // upper bound product has a zero factor
  } side_t;

  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] POS_ZERO  = 64'h0000_0000_0000_0000;

  // number of register stages inside one multiplier
  localparam int unsigned FMUL_STAGES = 7;

endpackage

>>> design/imd_fmul.sv
// ----------------------------------------------------------------------------
// imd_fmul - pipelined binary64 multiplier
// Round to nearest even, subnormals kept, NaN results canonical. Seven
// register stages, each loaded by its own enable bit.
// ----------------------------------------------------------------------------
module imd_fmul
  import imd_pkg::*;
(
  input  logic                   clk_i,
  input  logic [FMUL_STAGES-1:0] en_i,
  input  logic [63:0]            a_i,
  input  logic [63:0]            b_i,
  output logic [63:0]            p_o
);

  // leading zero count of a 53-bit significand
  function automatic logic [5:0] lzc53(input logic [52:0] m);
    logic [5:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = 52; i >= 0; i--) begin
      if (!found) begin
        if (m[i]) found = 1'b1;
        else      n = n + 6'd1;
      end
    end
    return n;
  endfunction

  typedef struct packed {
    logic sign;
    logic nan;
    logic inf;
    logic zero;
  } spec_t;

  // stage 1: unpack, specials, leading zeros
  logic [10:0] ea_f, eb_f;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  spec_t       s1_spec_d, s1_spec_q;
  logic [52:0] s1_ma_q, s1_mb_q;
  logic [10:0] s1_ea_q, s1_eb_q;
  logic [5:0]  s1_lza_q, s1_lzb_q;

  assign ea_f   = a_i[62:52];
  assign eb_f   = b_i[62:52];
  assign fa     = a_i[51:0];
  assign fb     = b_i[51:0];
  assign a_nan  = (ea_f == 11'h7FF) && (fa != '0);
  assign b_nan  = (eb_f == 11'h7FF) && (fb != '0);
  assign a_inf  = (ea_f == 11'h7FF) && (fa == '0);
  assign b_inf  = (eb_f == 11'h7FF) && (fb == '0);
  assign a_zero = (ea_f == '0) && (fa == '0);
  assign b_zero = (eb_f == '0) && (fb == '0);

  always_comb begin
    s1_spec_d.sign = a_i[63] ^ b_i[63];
    s1_spec_d.nan  = a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
    s1_spec_d.inf  = a_inf | b_inf;
    s1_spec_d.zero = a_zero | b_zero;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_spec_q <= s1_spec_d;
      s1_ma_q   <= {ea_f != '0, fa};
      s1_mb_q   <= {eb_f != '0, fb};
      s1_ea_q   <= (ea_f == '0) ? 11'd1 : ea_f;
      s1_eb_q   <= (eb_f == '0) ? 11'd1 : eb_f;
      s1_lza_q  <= lzc53({ea_f != '0, fa});
      s1_lzb_q  <= lzc53({eb_f != '0, fb});
    end
  end

  // stage 2: normalize significands, biased exponent of the product
  spec_t              s2_spec_q;
  logic [52:0]        s2_ma_q, s2_mb_q;
  logic signed [12:0] s2_exp_d, s2_exp_q;

  assign s2_exp_d = $signed(13'(s1_ea_q)) + $signed(13'(s1_eb_q))
                  - $signed(13'(s1_lza_q)) - $signed(13'(s1_lzb_q)) - 13'sd1023;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_spec_q <= s1_spec_q;
      s2_ma_q   <= s1_ma_q << s1_lza_q;
      s2_mb_q   <= s1_mb_q << s1_lzb_q;
      s2_exp_q  <= s2_exp_d;
    end
  end

  // stage 3: four partial products
  spec_t              s3_spec_q;
  logic signed [12:0] s3_exp_q;
  logic [51:0]        s3_hh_q;
  logic [52:0]        s3_hl_q, s3_lh_q;
  logic [53:0]        s3_ll_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_spec_q <= s2_spec_q;
      s3_exp_q  <= s2_exp_q;
      s3_hh_q   <= s2_ma_q[52:27] * s2_mb_q[52:27];
      s3_hl_q   <= s2_ma_q[52:27] * s2_mb_q[26:0];
      s3_lh_q   <= s2_ma_q[26:0]  * s2_mb_q[52:27];
      s3_ll_q   <= s2_ma_q[26:0]  * s2_mb_q[26:0];
    end
  end

  // stage 4: sum of partial products
  spec_t              s4_spec_q;
  logic signed [12:0] s4_exp_q;
  logic [105:0]       s4_p_q;
  logic [53:0]        mid;

  assign mid = 54'(s3_hl_q) + 54'(s3_lh_q);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_spec_q <= s3_spec_q;
      s4_exp_q  <= s3_exp_q;
      s4_p_q    <= {s3_hh_q, 54'd0} + {25'd0, mid, 27'd0} + {52'd0, s3_ll_q};
    end
  end

  // stage 5: one-bit normalize, overflow and subnormal shift amount
  spec_t              s5_spec_q;
  logic [105:0]       s5_n_q;
  logic [10:0]        s5_x_q;
  logic [6:0]         s5_sh_q;
  logic               s5_sub_q, s5_of_q;
  logic signed [12:0] x5;
  logic signed [12:0] sh_full;

  assign x5      = s4_p_q[105] ? (s4_exp_q + 13'sd1) : s4_exp_q;
  assign sh_full = 13'sd1 - x5;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s5_spec_q <= s4_spec_q;
      s5_n_q    <= s4_p_q[105] ? s4_p_q : {s4_p_q[104:0], 1'b0};
      s5_x_q    <= x5[10:0];
      s5_sub_q  <= (x5 <= 13'sd0);
      s5_of_q   <= (x5 >= 13'sd2047);
      s5_sh_q   <= (sh_full > 13'sd107) ? 7'd107 : sh_full[6:0];
    end
  end

  // stage 6: denormalize, guard and sticky, round decision
  spec_t        s6_spec_q;
  logic         s6_of_q, s6_rnd_q;
  logic [62:0]  s6_body_q;
  logic [105:0] nn, mask;
  logic         lost, guard, sticky;

  assign mask   = ~({106{1'b1}} << s5_sh_q);
  assign nn     = s5_sub_q ? (s5_n_q >> s5_sh_q) : s5_n_q;
  assign lost   = s5_sub_q && ((s5_n_q & mask) != '0);
  assign guard  = nn[52];
  assign sticky = (nn[51:0] != '0) | lost;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s6_spec_q <= s5_spec_q;
      s6_of_q   <= s5_of_q;
      s6_body_q <= {s5_sub_q ? 11'd0 : s5_x_q, nn[104:53]};
      s6_rnd_q  <= guard & (sticky | nn[53]);
    end
  end

  // stage 7: round and pick special results
  logic [63:0] p_d, p_q;
  logic [62:0] body_r;

  assign body_r = s6_body_q + 63'(s6_rnd_q);

  always_comb begin
    priority if (s6_spec_q.nan)                p_d = CANON_NAN;
    else if (s6_spec_q.inf || s6_of_q)         p_d = {s6_spec_q.sign, 11'h7FF, 52'd0};
    else if (s6_spec_q.zero)                   p_d = {s6_spec_q.sign, 63'd0};
    else                                       p_d = {s6_spec_q.sign, body_r};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

>>> design/interval_multiply_double.sv
// ----------------------------------------------------------------------------
// interval_multiply_double - binary64 interval multiplier
// Multiplies two intervals held as (minus lower bound, upper bound).
//
//  channel  dir  payload
//  s_axis   in   left_neg_low, left_high, right_neg_low, right_high
//  m_axis   out  product_neg_low, product_high
//
// One beat per cycle unless the output stalls; stages: select stage, seven
// multiplier stages, bound stage. Four binary64 multipliers run in parallel.
// Reset clears the stage valid bits only. A stalled output holds its beat;
// each stage advances when it is empty or its successor advances, so bubbles
// close up and upstream beats keep flowing.
// ----------------------------------------------------------------------------
module interval_multiply_double
  import imd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] left_neg_low, [127:64] left_high,
  // [191:128] right_neg_low, [255:192] right_high
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] product_neg_low, [127:64] product_high
  output logic [127:0] m_axis_tdata
);

  localparam int unsigned NSTG = FMUL_STAGES + 2;

  function automatic logic is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != '0);
  endfunction

  function automatic logic is_zero(input logic [63:0] x);
    return x[62:0] == '0;
  endfunction

  // x <= 0.0
  function automatic logic le_zero(input logic [63:0] x);
    return !is_nan(x) && (x[63] || is_zero(x));
  endfunction

  // a > b for non-NaN operands
  function automatic logic fp_gt(input logic [63:0] a, input logic [63:0] b);
    logic r;
    if (is_zero(a) && is_zero(b))   r = 1'b0;
    else if (a[63] != b[63])        r = !a[63];
    else if (!a[63])                r = a[62:0] > b[62:0];
    else                            r = a[62:0] < b[62:0];
    return r;
  endfunction

  // maximum that skips a single NaN
  function automatic logic [63:0] max_nz(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    if (is_nan(a))       r = b;
    else if (is_nan(b))  r = a;
    else                 r = fp_gt(a, b) ? a : b;
    return r;
  endfunction

  function automatic sign_class_e classify(input logic [63:0] nlo, input logic [63:0] hi);
    sign_class_e c;
    if (le_zero(nlo))      c = CLS_NONNEG;
    else if (le_zero(hi))  c = CLS_NONPOS;
    else                   c = CLS_STRADDLE;
    return c;
  endfunction

  // stage enables and valid bits
  logic [NSTG-1:0] v_q, en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];

  // stage 0: classify and route operands
  logic [63:0] bl, bh, cl, ch;
  logic [63:0] neg_bl, neg_cl, neg_ch;
  sign_class_e kb, kc;
  logic [63:0] a_d [4];
  logic [63:0] b_d [4];
  logic [63:0] a_q [4];
  logic [63:0] b_q [4];
  side_t       side_d;

  assign bl     = s_axis_tdata[63:0];
  assign bh     = s_axis_tdata[127:64];
  assign cl     = s_axis_tdata[191:128];
  assign ch     = s_axis_tdata[255:192];
  assign neg_bl = {~bl[63], bl[62:0]};
  assign neg_cl = {~cl[63], cl[62:0]};
  assign neg_ch = {~ch[63], ch[62:0]};
  assign kb     = classify(bl, bh);
  assign kc     = classify(cl, ch);

  // products 0/2 give the bounds; 1/3 are the second cross products
  always_comb begin
    a_d[0] = bh; b_d[0] = cl;
    a_d[1] = bl; b_d[1] = ch;
    a_d[2] = bl; b_d[2] = cl;
    a_d[3] = bh; b_d[3] = ch;
    unique case (kc)
      CLS_NONNEG: begin
        unique case (kb)
          CLS_NONNEG: begin
            a_d[0] = bl; b_d[0] = neg_cl; a_d[2] = bh; b_d[2] = ch;
          end
          CLS_NONPOS: begin
            a_d[0] = bl; b_d[0] = ch; a_d[2] = bh; b_d[2] = neg_cl;
          end
          default: begin
            a_d[0] = bl; b_d[0] = ch; a_d[2] = bh; b_d[2] = ch;
          end
        endcase
      end
      CLS_NONPOS: begin
        unique case (kb)
          CLS_NONNEG: begin
            a_d[0] = bh; b_d[0] = cl; a_d[2] = neg_bl; b_d[2] = ch;
          end
          CLS_NONPOS: begin
            a_d[0] = bh; b_d[0] = neg_ch; a_d[2] = bl; b_d[2] = cl;
          end
          default: begin
            a_d[0] = bh; b_d[0] = cl; a_d[2] = bl; b_d[2] = cl;
          end
        endcase
      end
      default: begin
        unique case (kb)
          CLS_NONNEG: begin
            a_d[0] = bh; b_d[0] = cl; a_d[2] = bh; b_d[2] = ch;
          end
          CLS_NONPOS: begin
            a_d[0] = bl; b_d[0] = ch; a_d[2] = bl; b_d[2] = cl;
          end
          default: begin
            a_d[0] = bh; b_d[0] = cl; a_d[2] = bl; b_d[2] = cl;
          end
        endcase
      end
    endcase
    side_d.both_straddle = (kb == CLS_STRADDLE) && (kc == CLS_STRADDLE);
    side_d.zf_low  = !side_d.both_straddle && (is_zero(a_d[0]) || is_zero(b_d[0]));
    side_d.zf_high = !side_d.both_straddle && (is_zero(a_d[2]) || is_zero(b_d[2]));
  end

  // sideband delay line alongside the multipliers
  side_t side_q [NSTG-1];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 4; i++) begin
        a_q[i] <= a_d[i];
        b_q[i] <= b_d[i];
      end
      side_q[0] <= side_d;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (en[k]) side_q[k] <= side_q[k-1];
    end
  end

  // stages 1..7: four multipliers
  logic [63:0] prod [4];

  for (genvar g = 0; g < 4; g++) begin : g_mul
    imd_fmul u_fmul (
      .clk_i (clk_i),
      .en_i  (en[FMUL_STAGES:1]),
      .a_i   (a_q[g]),
      .b_i   (b_q[g]),
      .p_o   (prod[g])
    );
  end

  // final stage: zero forcing or maxima, output register
  side_t       s7_side;
  logic [63:0] lo_d, hi_d, lo_q, hi_q;

  assign s7_side = side_q[NSTG-2];

  always_comb begin
    if (s7_side.both_straddle) begin
      lo_d = max_nz(prod[0], prod[1]);
      hi_d = max_nz(prod[2], prod[3]);
    end else begin
      lo_d = s7_side.zf_low  ? POS_ZERO : prod[0];
      hi_d = s7_side.zf_high ? POS_ZERO : prod[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign m_axis_tvalid = v_q[NSTG-1];
  assign m_axis_tdata  = {hi_q, lo_q};

endmodule

>>> tb/imd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imd_checker - scoreboard of the interval multiplier
// Watches both stream channels, predicts the product interval of every
// accepted input beat in binary64 and compares it with the output beats in
// order. Mismatches are reported one line each and counted.
// ----------------------------------------------------------------------------
module imd_checker
  import imd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [255:0] s_data_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [127:0] m_data_i,
  output int           errors_o,
  output int           pending_o,
  output int           checked_o
);

  typedef struct packed {
    logic [63:0] prod_high;
    logic [63:0] prod_neg_low;
  } bounds_t;

  bounds_t product_q[$];

  function automatic bit is_nan(logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != '0);
  endfunction

  function automatic bit is_zero(logic [63:0] b);
    return b[62:0] == '0;
  endfunction

  // b <= 0.0, false for NaN
  function automatic bit le_zero(logic [63:0] b);
    return !is_nan(b) && (b[63] || is_zero(b));
  endfunction

  function automatic logic [63:0] negate(logic [63:0] b);
    return {~b[63], b[62:0]};
  endfunction

  function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b);
    return $realtobits($bitstoreal(a) * $bitstoreal(b));
  endfunction

  // product forced to +0.0 when a factor is zero
  function automatic logic [63:0] fmul_zf(logic [63:0] a, logic [63:0] b);
    if (is_zero(a) || is_zero(b)) return POS_ZERO;
    return fmul(a, b);
  endfunction

  // maximum that skips a single NaN
  function automatic logic [63:0] fmax_skip_nan(logic [63:0] a, logic [63:0] b);
    if (is_nan(a)) return b;
    if (is_nan(b)) return a;
    return ($bitstoreal(a) > $bitstoreal(b)) ? a : b;
  endfunction

  function automatic sign_class_e classify(logic [63:0] nlo, logic [63:0] hi);
    if (le_zero(nlo)) return CLS_NONNEG;
    if (le_zero(hi)) return CLS_NONPOS;
    return CLS_STRADDLE;
  endfunction

  function automatic logic [63:0] canon(logic [63:0] b);
    return is_nan(b) ? CANON_NAN : b;
  endfunction

  function automatic bounds_t interval_product(logic [255:0] d);
    logic [63:0] bl, bh, cl, ch, rl, rh;
    sign_class_e kb, kc;
    bounds_t r;
    bl = d[63:0];
    bh = d[127:64];
    cl = d[191:128];
    ch = d[255:192];
    kb = classify(bl, bh);
    kc = classify(cl, ch);
    case (kc)
      CLS_NONNEG: begin
        case (kb)
          CLS_NONNEG: begin rl = fmul_zf(bl, negate(cl)); rh = fmul_zf(bh, ch); end
          CLS_NONPOS: begin rl = fmul_zf(bl, ch); rh = fmul_zf(bh, negate(cl)); end
          default:    begin rl = fmul_zf(bl, ch); rh = fmul_zf(bh, ch); end
        endcase
      end
      CLS_NONPOS: begin
        case (kb)
          CLS_NONNEG: begin rl = fmul_zf(bh, cl); rh = fmul_zf(negate(bl), ch); end
          CLS_NONPOS: begin rl = fmul_zf(bh, negate(ch)); rh = fmul_zf(bl, cl); end
          default:    begin rl = fmul_zf(bh, cl); rh = fmul_zf(bl, cl); end
        endcase
      end
      default: begin
        case (kb)
          CLS_NONNEG: begin rl = fmul_zf(bh, cl); rh = fmul_zf(bh, ch); end
          CLS_NONPOS: begin rl = fmul_zf(bl, ch); rh = fmul_zf(bl, cl); end
          default: begin
            rl = fmax_skip_nan(fmul(bh, cl), fmul(bl, ch));
            rh = fmax_skip_nan(fmul(bl, cl), fmul(bh, ch));
          end
        endcase
      end
    endcase
    r.prod_neg_low = canon(rl);
    r.prod_high    = canon(rh);
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors_o++;
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  // input side predicts, output side compares
  always @(posedge clk_i or negedge rst_ni) begin
    bounds_t want;
    if (!rst_ni) begin
      product_q.delete();
    end else begin
      if (s_valid_i && s_ready_i) product_q.push_back(interval_product(s_data_i));
      if (m_valid_i && m_ready_i) begin
        if (product_q.size() == 0) begin
          errors_o++;
          $display("[%0t] output beat with nothing expected: %h", $realtime, m_data_i);
        end else begin
          want = product_q.pop_front();
          checked_o++;
          if (m_data_i[63:0] !== want.prod_neg_low)
            report("product_neg_low", m_data_i[63:0], want.prod_neg_low);
          if (m_data_i[127:64] !== want.prod_high)
            report("product_high", m_data_i[127:64], want.prod_high);
        end
      end
    end
    pending_o = product_q.size();
  end

  initial begin
    errors_o  = 0;
    pending_o = 0;
    checked_o = 0;
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - stream test of the binary64 interval multiplier
// Directed intervals over all sign class pairs, zeros, infinities and NaNs,
// then random intervals with random source and sink stalls. The checker
// module scores every output beat.
// ----------------------------------------------------------------------------
module testbench;
  import imd_pkg::*;

  localparam int NUM_RANDOM = 600;
  localparam int IDLE_LIMIT = 3000;

  localparam logic [63:0] D_ONE  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] D_TWO  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] D_INF  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] D_MAX  = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] D_SUB  = 64'h0000_0000_0000_0001;
  localparam logic [63:0] D_NAN  = 64'h7FF4_0000_0000_00AB;
  localparam logic [63:0] SGN    = 64'h8000_0000_0000_0000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;

  int  errors, pending, checked;
  int  idle_cycles;
  bit  sink_busy_free;
  bit  source_busy_free;

  interval_multiply_double dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  imd_checker u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // magnitude of a binary64 value, biased toward special encodings
  function automatic logic [62:0] magnitude();
    case ($urandom_range(0, 9))
      0: return 63'd0;
      1: return D_INF[62:0];
      2: return {11'h7FF, 52'd1 + 52'($urandom_range(0, 1000)) + {20'd0, 32'($urandom)}};
      3: return {11'd0, 52'($urandom) | {20'($urandom), 32'd0}};
      4: return D_MAX[62:0];
      5: return D_ONE[62:0];
      6: return {11'($urandom_range(1000, 1046)), 20'($urandom), 32'($urandom)};
      default: return 63'({$urandom, $urandom});
    endcase
  endfunction

  // one interval as (neg_low, high) with a random sign class
  function automatic logic [127:0] interval();
    logic [63:0] nlo, hi;
    case ($urandom_range(0, 4))
      0: begin nlo = {1'b1, magnitude()}; hi = {1'b0, magnitude()}; end
      1: begin nlo = {1'b0, magnitude()}; hi = {1'b1, magnitude()}; end
      2: begin nlo = {1'b0, magnitude()}; hi = {1'b0, magnitude()}; end
      3: begin nlo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
      default: begin nlo = {1'($urandom), magnitude()}; hi = {1'($urandom), magnitude()}; end
    endcase
    return {hi, nlo};
  endfunction

  // drive one input beat and hold it until accepted
  task automatic send(logic [63:0] bl, logic [63:0] bh, logic [63:0] cl, logic [63:0] ch);
    bit taken;
    int g;
    g = source_busy_free ? 0 : gap_len();
    repeat (g) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ch, cl, bh, bl};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // sink stalls
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (sink_busy_free) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 9) < 7);
  end

  // watchdog on cycles with no beat accepted anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [127:0] a, b;
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    m_axis_tready    = 1'b0;
    idle_cycles      = 0;
    sink_busy_free   = 1'b0;
    source_busy_free = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every class pair with plain values
    send(SGN | D_ONE, D_TWO, SGN | D_ONE, D_TWO);       // nonneg x nonneg
    send(SGN | D_ONE, D_TWO, D_TWO, SGN | D_ONE);       // nonneg x nonpos
    send(SGN | D_ONE, D_TWO, D_TWO, D_ONE);             // nonneg x straddle
    send(D_TWO, SGN | D_ONE, SGN | D_ONE, D_TWO);       // nonpos x nonneg
    send(D_TWO, SGN | D_ONE, D_TWO, SGN | D_ONE);       // nonpos x nonpos
    send(D_TWO, SGN | D_ONE, D_ONE, D_TWO);             // nonpos x straddle
    send(D_ONE, D_TWO, SGN | D_ONE, D_TWO);             // straddle x nonneg
    send(D_ONE, D_TWO, D_TWO, SGN | D_ONE);             // straddle x nonpos
    send(D_ONE, D_TWO, D_TWO, D_ONE);                   // both straddle
    // zero factor against infinity, both zero signs
    send(64'd0, D_INF, SGN | D_INF, SGN);
    send(SGN, 64'd0, D_INF, D_INF);
    send(64'd0, 64'd0, D_INF, D_INF);                   // [0,0] is nonneg
    // NaN bounds and both straddling with one NaN cross product
    send(D_NAN, D_TWO, D_ONE, D_ONE);
    send(D_ONE, D_NAN, D_NAN, D_ONE);
    send(D_INF, D_INF, D_INF, D_INF);
    send(D_INF, 64'd0 | D_ONE, D_ONE, D_INF);
    // extremes: overflow, subnormals, all ones
    send(SGN | D_MAX, D_MAX, SGN | D_MAX, D_MAX);
    send(SGN | D_SUB, D_SUB, SGN | D_SUB, D_SUB);
    send(D_MAX, D_SUB, D_SUB, D_MAX);
    send('1, '1, '1, '1);
    send(SGN | D_SUB, D_ONE, D_TWO, SGN | 64'h3CB0_0000_0000_0000);
    drain();

    // random part with phases of no idling on either side
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 150 == 0) begin
        source_busy_free = ($urandom_range(0, 2) == 0);
        sink_busy_free   = ($urandom_range(0, 2) == 0);
      end
      if (i == NUM_RANDOM / 2) drain();
      a = interval();
      b = interval();
      send(a[63:0], a[127:64], b[63:0], b[127:64]);
    end
    s_axis_tvalid <= 1'b0;
    drain();
    repeat (30) @(posedge clk_i);

    $display("Covered %0d products: all sign class pairs, zeros, infinities, NaNs,",
             checked);
    $display("subnormals and overflow, under random source and sink stalls.");
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/imd_pkg.sv
design/imd_fmul.sv
design/interval_multiply_double.sv
tb/imd_checker.sv
tb/testbench.sv
